@@ rtl/hrcd_pkg.sv @@
// Shared types, constants and character tables for the HTTP request completeness detector.
`default_nettype none

package hrcd_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    localparam logic [4:0] TE_LEN    = 5'd17;
    localparam logic [4:0] CL_LEN    = 5'd14;
    localparam logic [4:0] NAME_FAIL = 5'd31;
    localparam logic [2:0] CHUNK_LEN = 3'd7;

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5a;
    localparam logic [7:0] CHAR_LC_C  = 8'h63;

    // One classified request byte as it travels from the front to the back.
    typedef struct packed {
        logic [7:0] ch;
        logic       is_cr;
        logic       is_lf;
        logic       is_colon;
        logic       is_blank;
        logic       is_digit;
        logic       start;
    } word_t;

    typedef enum logic [1:0] {
        LP_NAME,
        LP_TE_VALUE,
        LP_CL_VALUE,
        LP_SKIP
    } line_phase_t;

    typedef enum logic [1:0] {
        LEN_LEAD,
        LEN_DIGITS,
        LEN_TRAIL
    } len_phase_t;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_LENGTH,
        MODE_CHUNKED
    } mode_t;

    // Progress through CR LF 0 CR LF CR LF in a chunked body.
    typedef enum logic [2:0] {
        CK_IDLE,
        CK_CR,
        CK_CRLF,
        CK_ZERO,
        CK_ZERO_CR,
        CK_ZERO_CRLF,
        CK_FINAL_CR
    } chunk_state_t;

    function automatic logic [7:0] te_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "t";
            5'd1:    c = "r";
            5'd2:    c = "a";
            5'd3:    c = "n";
            5'd4:    c = "s";
            5'd5:    c = "f";
            5'd6:    c = "e";
            5'd7:    c = "r";
            5'd8:    c = "-";
            5'd9:    c = "e";
            5'd10:   c = "n";
            5'd11:   c = "c";
            5'd12:   c = "o";
            5'd13:   c = "d";
            5'd14:   c = "i";
            5'd15:   c = "n";
            5'd16:   c = "g";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cl_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "c";
            5'd1:    c = "o";
            5'd2:    c = "n";
            5'd3:    c = "t";
            5'd4:    c = "e";
            5'd5:    c = "n";
            5'd6:    c = "t";
            5'd7:    c = "-";
            5'd8:    c = "l";
            5'd9:    c = "e";
            5'd10:   c = "n";
            5'd11:   c = "g";
            5'd12:   c = "t";
            5'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] chunk_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = "c";
            3'd1:    c = "h";
            3'd2:    c = "u";
            3'd3:    c = "n";
            3'd4:    c = "k";
            3'd5:    c = "e";
            3'd6:    c = "d";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/hrcd_front.sv @@
// Front end: accepts request bytes and classifies each one into a queue word.
`default_nettype none

module hrcd_front
    import hrcd_pkg::*;
(
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       start_of_request,
    input  wire logic       q_full,
    output logic            q_push,
    output word_t           q_word
);

    logic is_upper;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    assign is_upper = (data_byte >= CHAR_UC_A) && (data_byte <= CHAR_UC_Z);

    always_comb
    begin
        q_word.ch       = is_upper ? (data_byte + 8'd32) : data_byte;
        q_word.is_cr    = (data_byte == CHAR_CR);
        q_word.is_lf    = (data_byte == CHAR_LF);
        q_word.is_colon = (data_byte == CHAR_COLON);
        q_word.is_blank = (data_byte == CHAR_SPACE) || (data_byte == CHAR_TAB);
        q_word.is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
        q_word.start    = start_of_request;
    end

endmodule

`default_nettype wire

@@ rtl/hrcd_queue.sv @@
// Two-word queue that decouples the byte classifier from the framing engine.
`default_nettype none

module hrcd_queue
    import hrcd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire word_t push_word,
    output logic       full,
    input  wire logic  pop,
    output word_t      head,
    output logic       not_empty
);

    word_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

@@ rtl/hrcd_back.sv @@
// Framing engine: tracks header lines, length or chunk framing, and registers each result.
`default_nettype none

module hrcd_back
    import hrcd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire word_t      q_head,
    input  wire logic       q_not_empty,
    output logic            q_pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            complete,
    output logic            header_done,
    output logic [1:0]      framing_mode,
    output logic            length_invalid
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic [1:0]             term_reg,      term_next;
    logic                   hdr_fin_reg,   hdr_fin_next;
    line_phase_t            line_reg,      line_next;
    logic [4:0]             te_match_reg,  te_match_next;
    logic [4:0]             cl_match_reg,  cl_match_next;
    logic                   te_seen_reg,   te_seen_next;
    logic                   cl_seen_reg,   cl_seen_next;
    logic [2:0]             ck_word_reg,   ck_word_next;
    logic                   chunked_reg,   chunked_next;
    len_phase_t             lphase_reg,    lphase_next;
    logic [LENGTH_BITS-1:0] lval_reg,      lval_next;
    logic                   lnonempty_reg, lnonempty_next;
    logic                   lbad_reg,      lbad_next;
    logic [LENGTH_BITS-1:0] body_reg,      body_next;
    chunk_state_t           ck_reg,        ck_next;
    logic                   done_reg,      done_next;

    logic                   out_valid_reg;
    logic                   complete_reg;
    logic                   header_done_reg;
    mode_t                  mode_reg,      mode_next;
    logic                   linv_reg;

    logic [LENGTH_BITS+3:0] lval_wide;
    logic [LENGTH_BITS+3:0] lval_prod;
    logic [LENGTH_BITS-1:0] need;
    logic                   framed;
    logic                   term_hit;
    word_t                  w;

    assign w     = q_head;
    assign q_pop = q_not_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        // A start word clears all state before the byte is taken.
        if (w.start)
        begin
            term_next      = 2'd0;
            hdr_fin_next   = 1'b0;
            line_next      = LP_NAME;
            te_match_next  = 5'd0;
            cl_match_next  = 5'd0;
            te_seen_next   = 1'b0;
            cl_seen_next   = 1'b0;
            ck_word_next   = 3'd0;
            chunked_next   = 1'b0;
            lphase_next    = LEN_LEAD;
            lval_next      = '0;
            lnonempty_next = 1'b0;
            lbad_next      = 1'b0;
            body_next      = '0;
            ck_next        = CK_IDLE;
            done_next      = 1'b0;
        end
        else
        begin
            term_next      = term_reg;
            hdr_fin_next   = hdr_fin_reg;
            line_next      = line_reg;
            te_match_next  = te_match_reg;
            cl_match_next  = cl_match_reg;
            te_seen_next   = te_seen_reg;
            cl_seen_next   = cl_seen_reg;
            ck_word_next   = ck_word_reg;
            chunked_next   = chunked_reg;
            lphase_next    = lphase_reg;
            lval_next      = lval_reg;
            lnonempty_next = lnonempty_reg;
            lbad_next      = lbad_reg;
            body_next      = body_reg;
            ck_next        = ck_reg;
            done_next      = done_reg;
        end

        lval_wide = '0;
        lval_prod = '0;
        need      = '0;
        framed    = 1'b0;
        term_hit  = 1'b0;

        if (!done_next)
        begin
            if (!hdr_fin_next)
            begin
                // Header line tracking.
                if (w.is_lf)
                begin
                    line_next     = LP_NAME;
                    te_match_next = 5'd0;
                    cl_match_next = 5'd0;
                end
                else
                begin
                    case (line_next)
                        LP_NAME:
                        begin
                            if (w.is_colon)
                            begin
                                if (te_match_next == TE_LEN && !te_seen_next)
                                begin
                                    te_seen_next = 1'b1;
                                    line_next    = LP_TE_VALUE;
                                end
                                else if (cl_match_next == CL_LEN && !cl_seen_next)
                                begin
                                    cl_seen_next = 1'b1;
                                    line_next    = LP_CL_VALUE;
                                end
                                else
                                begin
                                    line_next = LP_SKIP;
                                end
                            end
                            else
                            begin
                                if (te_match_next < TE_LEN && w.ch == te_char(te_match_next))
                                begin
                                    te_match_next = te_match_next + 5'd1;
                                end
                                else
                                begin
                                    te_match_next = NAME_FAIL;
                                end
                                if (cl_match_next < CL_LEN && w.ch == cl_char(cl_match_next))
                                begin
                                    cl_match_next = cl_match_next + 5'd1;
                                end
                                else
                                begin
                                    cl_match_next = NAME_FAIL;
                                end
                            end
                        end
                        LP_TE_VALUE:
                        begin
                            if (w.ch == chunk_char(ck_word_next))
                            begin
                                ck_word_next = ck_word_next + 3'd1;
                            end
                            else
                            begin
                                ck_word_next = (w.ch == CHAR_LC_C) ? 3'd1 : 3'd0;
                            end
                            if (ck_word_next == CHUNK_LEN)
                            begin
                                chunked_next = 1'b1;
                                ck_word_next = 3'd0;
                            end
                        end
                        LP_CL_VALUE:
                        begin
                            if (!(lphase_next == LEN_LEAD && w.is_blank))
                            begin
                                if (w.is_blank || w.is_cr)
                                begin
                                    lphase_next = LEN_TRAIL;
                                end
                                else
                                begin
                                    if (lphase_next == LEN_TRAIL || !w.is_digit)
                                    begin
                                        lbad_next = 1'b1;
                                    end
                                    lphase_next    = LEN_DIGITS;
                                    lnonempty_next = 1'b1;
                                    if (!lbad_next)
                                    begin
                                        lval_wide = {4'd0, lval_next};
                                        lval_prod = (lval_wide << 3) + (lval_wide << 1)
                                                    + {{LENGTH_BITS{1'b0}}, w.ch[3:0]};
                                        if (lval_prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                                        begin
                                            lval_next = LEN_MAX;
                                        end
                                        else
                                        begin
                                            lval_next = lval_prod[LENGTH_BITS-1:0];
                                        end
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            line_next = LP_SKIP;
                        end
                    endcase
                end

                // Header terminator search.
                term_hit = term_next[0] ? w.is_lf : w.is_cr;
                if (term_next == 2'd3 && w.is_lf)
                begin
                    hdr_fin_next = 1'b1;
                    framed = !chunked_next && cl_seen_next && lnonempty_next;
                    need   = lbad_next ? '0 : lval_next;
                    if (chunked_next)
                    begin
                        // The body starts as if a CR LF preceded it.
                        ck_next = CK_CRLF;
                    end
                    else if (framed)
                    begin
                        if (body_next >= need)
                        begin
                            done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
                else if (term_hit)
                begin
                    term_next = term_next + 2'd1;
                end
                else
                begin
                    term_next = w.is_cr ? 2'd1 : 2'd0;
                end
            end
            else if (chunked_next)
            begin
                case (ck_next)
                    CK_CR:        ck_next = w.is_lf ? CK_CRLF : (w.is_cr ? CK_CR : CK_IDLE);
                    CK_CRLF:      ck_next = (w.ch == CHAR_ZERO) ? CK_ZERO
                                          : (w.is_cr ? CK_CR : CK_IDLE);
                    CK_ZERO:      ck_next = w.is_cr ? CK_ZERO_CR : CK_IDLE;
                    CK_ZERO_CR:   ck_next = w.is_lf ? CK_ZERO_CRLF
                                          : (w.is_cr ? CK_CR : CK_IDLE);
                    CK_ZERO_CRLF: ck_next = w.is_cr ? CK_FINAL_CR
                                          : ((w.ch == CHAR_ZERO) ? CK_ZERO : CK_IDLE);
                    CK_FINAL_CR:
                    begin
                        if (w.is_lf)
                        begin
                            done_next = 1'b1;
                            ck_next   = CK_IDLE;
                        end
                        else
                        begin
                            ck_next = w.is_cr ? CK_CR : CK_IDLE;
                        end
                    end
                    default:      ck_next = w.is_cr ? CK_CR : CK_IDLE;
                endcase
            end
            else
            begin
                if (body_next != LEN_MAX)
                begin
                    body_next = body_next + LENGTH_BITS'(1);
                end
                need = lbad_next ? '0 : lval_next;
                if (body_next >= need)
                begin
                    done_next = 1'b1;
                end
            end
        end

        mode_next = MODE_NONE;
        if (hdr_fin_next)
        begin
            if (chunked_next)
            begin
                mode_next = MODE_CHUNKED;
            end
            else if (cl_seen_next && lnonempty_next)
            begin
                mode_next = MODE_LENGTH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg      <= 2'd0;
            hdr_fin_reg   <= 1'b0;
            line_reg      <= LP_NAME;
            te_match_reg  <= 5'd0;
            cl_match_reg  <= 5'd0;
            te_seen_reg   <= 1'b0;
            cl_seen_reg   <= 1'b0;
            ck_word_reg   <= 3'd0;
            chunked_reg   <= 1'b0;
            lphase_reg    <= LEN_LEAD;
            lval_reg      <= '0;
            lnonempty_reg <= 1'b0;
            lbad_reg      <= 1'b0;
            body_reg      <= '0;
            ck_reg        <= CK_IDLE;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                term_reg      <= term_next;
                hdr_fin_reg   <= hdr_fin_next;
                line_reg      <= line_next;
                te_match_reg  <= te_match_next;
                cl_match_reg  <= cl_match_next;
                te_seen_reg   <= te_seen_next;
                cl_seen_reg   <= cl_seen_next;
                ck_word_reg   <= ck_word_next;
                chunked_reg   <= chunked_next;
                lphase_reg    <= lphase_next;
                lval_reg      <= lval_next;
                lnonempty_reg <= lnonempty_next;
                lbad_reg      <= lbad_next;
                body_reg      <= body_next;
                ck_reg        <= ck_next;
                done_reg      <= done_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            complete_reg    <= done_next;
            header_done_reg <= hdr_fin_next;
            mode_reg        <= mode_next;
            linv_reg        <= (mode_next == MODE_LENGTH) && lbad_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign complete       = complete_reg;
    assign header_done    = header_done_reg;
    assign framing_mode   = mode_reg;
    assign length_invalid = linv_reg;

endmodule

`default_nettype wire

@@ rtl/http_request_completeness_detector.sv @@
// Top level of the HTTP request completeness detector.
`default_nettype none

// Usage:
// The input channel (in_valid, in_stall, data_byte, start_of_request) takes one
// request byte per word. Setting start_of_request clears all tracking state
// before that byte is taken as the first byte of a new request.
// The output channel (out_valid, out_stall, complete, header_done,
// framing_mode, length_invalid) returns exactly one result word per input word.
// Throughput is one word per cycle while out_stall is low; an accepted word
// is first written to the queue and then its result is registered behind
// out_valid. The framing engine updates all of its state for each byte it takes, which sets that rate.
// A two-word queue sits between the byte classifier and the framing engine.
// When the receiver stalls, the result register holds and the queue fills;
// in_stall rises once both queue words are occupied.
// After reset both channels are empty and the block is ready for a new request.

module http_request_completeness_detector
    import hrcd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       start_of_request,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            complete,
    output logic            header_done,
    output logic [1:0]      framing_mode,
    output logic            length_invalid
);

    logic  q_full;
    logic  q_push;
    word_t q_word;
    logic  q_pop;
    word_t q_head;
    logic  q_not_empty;

    hrcd_front u_front (
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .start_of_request (start_of_request),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_word           (q_word)
    );

    hrcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_word),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty)
    );

    hrcd_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_head         (q_head),
        .q_not_empty    (q_not_empty),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .complete       (complete),
        .header_done    (header_done),
        .framing_mode   (framing_mode),
        .length_invalid (length_invalid)
    );

endmodule

`default_nettype wire

@@ rtl/hrcd_checker.sv @@
// Port-level checks for the HTTP request completeness detector, bound to the top level.
`default_nettype none

module hrcd_checker
    import hrcd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [7:0] data_byte,
    input wire logic       start_of_request,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       complete,
    input wire logic       header_done,
    input wire logic [1:0] framing_mode,
    input wire logic       length_invalid
);

    // Reset leaves no result word presented.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high during reset");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(data_byte)
                                 && $stable(start_of_request))
        else $error("stalled input word changed");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(complete)
                                   && $stable(header_done) && $stable(framing_mode)
                                   && $stable(length_invalid))
        else $error("stalled result word changed");

    // Framing is only decided once the header has ended.
    a_mode_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (framing_mode != MODE_NONE) |-> header_done)
        else $error("framing mode reported before header end");

    a_invalid_only_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && length_invalid |-> (framing_mode == MODE_LENGTH) && header_done)
        else $error("length_invalid outside content-length framing");

endmodule

bind http_request_completeness_detector hrcd_checker u_hrcd_checker (.*);

`default_nettype wire
